>>> rtl/dqpi_pkg.sv
`timescale 1ns / 1ps

package dqpi_pkg;

	// integrator width default and internal working width
	localparam int DATA_WIDTH_DEF = 32;
	localparam int WIDE = 64;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INDUCTANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd4;

	// 0.95 in Q0.16
	localparam logic [31:0] MOD_LIMIT_Q16 = 32'd62259;

	// iteration counts of the shared root and divide units
	localparam int ITER_W = 6;
	localparam logic [ITER_W-1:0] SQRT_DONE = 6'd32;
	localparam logic [ITER_W-1:0] DIV_LAST = 6'd63;

	typedef struct packed {
		logic signed [31:0] current_d;
		logic signed [31:0] current_q;
		logic signed [31:0] current_setpoint;
		logic signed [31:0] electrical_speed;
		logic [30:0]        bus_voltage;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] voltage_d;
		logic signed [31:0] voltage_q;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_NORM, ST_SQRT, ST_DIV, ST_DIV_END, ST_OUT
	} ctrl_state_t;

	typedef enum logic [2:0] {
		DP_IDLE, DP_LOAD, DP_MUL, DP_NORM, DP_SQRT, DP_DIV, DP_DIV_END, DP_OUT
	} dp_op_t;

	// products in issue order
	typedef enum logic [3:0] {
		PR_BUS, PR_LW, PR_FFQ, PR_FFD, PR_PD, PR_PQ,
		PR_SD2, PR_SQ2, PR_ND, PR_NQ, PR_ID, PR_IQ
	} prod_t;

	typedef struct packed {
		dp_op_t     op;
		prod_t      prod;
		logic [1:0] phase;
	} dp_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic limit;
		logic m_zero;
	} dp_status_t;

	function automatic logic [WIDE-1:0] apply_sign(input logic [WIDE-1:0] m, input logic neg);
		return neg ? (64'd0 - m) : m;
	endfunction

	function automatic logic [WIDE-1:0] mag64(input logic [WIDE-1:0] v);
		return v[WIDE-1] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

>>> rtl/dqpi_ctrl.sv
`timescale 1ns / 1ps

module dqpi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  dqpi_pkg::dp_status_t status,
	output dqpi_pkg::dp_cmd_t    cmd
);
	import dqpi_pkg::*;

	ctrl_state_t state_q, state_n;
	prod_t prod_q, prod_n;
	logic [1:0] phase_q, phase_n;
	logic [ITER_W-1:0] iter_q, iter_n;
	logic out_valid_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_q <= PR_BUS;
			phase_q <= 2'd0;
			iter_q <= '0;
		end else begin
			state_q <= state_n;
			prod_q <= prod_n;
			phase_q <= phase_n;
			iter_q <= iter_n;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_n = state_q;
		prod_n = prod_q;
		phase_n = phase_q;
		iter_n = iter_q;
		cmd.op = DP_IDLE;
		cmd.prod = prod_q;
		cmd.phase = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = DP_LOAD;
					state_n = ST_MUL;
					prod_n = PR_BUS;
					phase_n = 2'd0;
				end
			end
			ST_MUL: begin
				cmd.op = DP_MUL;
				phase_n = phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					case (prod_q)
						PR_PQ: state_n = ST_NORM;
						PR_SQ2: begin
							state_n = ST_SQRT;
							iter_n = '0;
						end
						PR_ND, PR_NQ: begin
							state_n = ST_DIV;
							iter_n = '0;
						end
						PR_IQ: state_n = ST_OUT;
						default: prod_n = prod_t'(prod_q + 4'd1);
					endcase
				end
			end
			ST_NORM: begin
				if (status.norm_done) begin
					state_n = ST_MUL;
					prod_n = PR_SD2;
				end else begin
					cmd.op = DP_NORM;
				end
			end
			ST_SQRT: begin
				if (iter_q == SQRT_DONE) begin
					// decide whether the vector needs scaling
					state_n = ST_MUL;
					prod_n = status.limit ? PR_ND : PR_ID;
				end else begin
					cmd.op = DP_SQRT;
					iter_n = iter_q + 6'd1;
				end
			end
			ST_DIV: begin
				cmd.op = DP_DIV;
				iter_n = iter_q + 6'd1;
				if (iter_q == DIV_LAST) begin
					state_n = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.op = DP_DIV_END;
				state_n = ST_MUL;
				prod_n = (prod_q == PR_ND) ? PR_NQ : PR_ID;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op = DP_OUT;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == DP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> rtl/dqpi_dp.sv
`timescale 1ns / 1ps

module dqpi_dp #(
	parameter int DATA_WIDTH = dqpi_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dqpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dqpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  dqpi_pkg::in_item_t                  in_data,
	input  dqpi_pkg::dp_cmd_t                   cmd,
	output dqpi_pkg::dp_status_t                status,
	output dqpi_pkg::out_item_t                 out_data
);
	import dqpi_pkg::*;

	localparam logic signed [WIDE-1:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [WIDE-1:0] SAT_LO = -SAT_HI - 64'sd1;

	logic [30:0] vlim_q, elim_q, kp_q;
	logic [31:0] ind_q;
	logic [15:0] ki_q;
	logic signed [DATA_WIDTH-1:0] integ_d_q, integ_q_q;

	logic signed [31:0] cur_d_q, cur_q_q, spd_q, eq_q;
	logic [30:0] vbus_q, vmax_q;

	logic [WIDE-1:0] mp_q, acc_q;
	logic [31:0] lw_mag_q;
	logic lw_neg_q;
	logic [WIDE-1:0] ccd_q, ccq_q, vd_q, vq_q, sd_q, sq_q, sqd_q;
	logic knz_q;
	logic [WIDE-1:0] x_q, r_q, bit_q, num_q;
	logic [31:0] rem_q;
	out_item_t out_q;

	logic signed [32:0] ediff, elim_s;
	logic signed [31:0] eq_n;
	logic [WIDE-1:0] op_a;
	logic [31:0] op_b;
	logic wb_neg;
	logic [WIDE-1:0] p16, sgn_p16, diff_d, diff_q, vq_new;
	logic [WIDE-1:0] integ_d_ext, integ_q_ext, integ_sum;
	logic [WIDE-1:0] rb;
	logic [32:0] rem_sh;
	logic div_bit;
	logic [30:0] bus_max;
	logic signed [DATA_WIDTH-1:0] integ_sat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlim_q <= '0;
			elim_q <= '0;
			ind_q <= '0;
			kp_q <= '0;
			ki_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLTAGE_LIMIT: vlim_q <= cfg_data[30:0];
				REG_ERROR_LIMIT: elim_q <= cfg_data[30:0];
				REG_INDUCTANCE: ind_q <= cfg_data;
				REG_PROP_GAIN: kp_q <= cfg_data[30:0];
				REG_INTEGRAL_GAIN: ki_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// clamped q error
	always_comb begin
		ediff = {in_data.current_setpoint[31], in_data.current_setpoint}
			- {in_data.current_q[31], in_data.current_q};
		elim_s = $signed({2'b00, elim_q});
		if (ediff > elim_s) begin
			eq_n = elim_s[31:0];
		end else if (ediff < -elim_s) begin
			eq_n = 32'(-elim_s);
		end else begin
			eq_n = ediff[31:0];
		end
	end

	assign integ_d_ext = {{(WIDE - DATA_WIDTH){integ_d_q[DATA_WIDTH-1]}}, integ_d_q};
	assign integ_q_ext = {{(WIDE - DATA_WIDTH){integ_q_q[DATA_WIDTH-1]}}, integ_q_q};
	assign diff_d = vd_q - ccd_q;
	assign diff_q = vq_q - ccq_q;

	// multiplier operand and sign selection
	always_comb begin
		op_a = '0;
		op_b = '0;
		wb_neg = 1'b0;
		case (cmd.prod)
			PR_BUS: begin
				op_a = {33'd0, vbus_q};
				op_b = MOD_LIMIT_Q16;
			end
			PR_LW: begin
				op_a = {32'd0, ind_q};
				op_b = mag32(spd_q);
			end
			PR_FFQ: begin
				op_a = {32'd0, lw_mag_q};
				op_b = mag32(cur_q_q);
				wb_neg = lw_neg_q ^ cur_q_q[31];
			end
			PR_FFD: begin
				op_a = {32'd0, lw_mag_q};
				op_b = mag32(cur_d_q);
				wb_neg = lw_neg_q ^ cur_d_q[31];
			end
			PR_PD: begin
				op_a = {33'd0, kp_q};
				op_b = mag32(cur_d_q);
				wb_neg = !cur_d_q[31] && (cur_d_q != 32'sd0);
			end
			PR_PQ: begin
				op_a = {33'd0, kp_q};
				op_b = mag32(eq_q);
				wb_neg = eq_q[31];
			end
			PR_SD2: begin
				op_a = sd_q;
				op_b = sd_q[31:0];
			end
			PR_SQ2: begin
				op_a = sq_q;
				op_b = sq_q[31:0];
			end
			PR_ND: begin
				op_a = sd_q;
				op_b = {1'b0, vmax_q};
			end
			PR_NQ: begin
				op_a = sq_q;
				op_b = {1'b0, vmax_q};
			end
			PR_ID: begin
				op_a = mag64(diff_d);
				op_b = {16'd0, ki_q};
				wb_neg = diff_d[WIDE-1];
			end
			PR_IQ: begin
				op_a = mag64(diff_q);
				op_b = {16'd0, ki_q};
				wb_neg = diff_q[WIDE-1];
			end
			default: ;
		endcase
	end

	// writeback helpers
	assign p16 = acc_q >> 16;
	assign sgn_p16 = apply_sign(p16, wb_neg);
	assign vq_new = sgn_p16 + ccq_q;
	assign bus_max = p16[30:0];
	assign integ_sum = ((cmd.prod == PR_ID) ? integ_d_ext : integ_q_ext) + sgn_p16;

	// integrator saturation
	always_comb begin
		if ($signed(integ_sum) > SAT_HI) begin
			integ_sat = SAT_HI[DATA_WIDTH-1:0];
		end else if ($signed(integ_sum) < SAT_LO) begin
			integ_sat = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			integ_sat = integ_sum[DATA_WIDTH-1:0];
		end
	end

	// root and divide steps
	assign rb = r_q + bit_q;
	assign rem_sh = {rem_q, num_q[WIDE-1]};
	assign div_bit = (rem_sh >= {1'b0, r_q[31:0]});

	// integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_d_q <= '0;
			integ_q_q <= '0;
		end else if (cmd.op == DP_MUL && cmd.phase == 2'd3) begin
			if (cmd.prod == PR_ID) begin
				integ_d_q <= integ_sat;
			end else if (cmd.prod == PR_IQ) begin
				integ_q_q <= integ_sat;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				cur_d_q <= in_data.current_d;
				cur_q_q <= in_data.current_q;
				spd_q <= in_data.electrical_speed;
				vbus_q <= in_data.bus_voltage;
				eq_q <= eq_n;
			end
			DP_MUL: begin
				case (cmd.phase)
					2'd0: mp_q <= {32'd0, op_a[31:0]} * {32'd0, op_b};
					2'd1: begin
						acc_q <= mp_q;
						mp_q <= {32'd0, op_a[63:32]} * {32'd0, op_b};
					end
					2'd2: acc_q <= acc_q + {mp_q[31:0], 32'd0};
					default: begin
						case (cmd.prod)
							PR_BUS: vmax_q <= (vlim_q < bus_max) ? vlim_q : bus_max;
							PR_LW: begin
								lw_mag_q <= acc_q[63:32];
								lw_neg_q <= spd_q[31];
							end
							PR_FFQ: ccd_q <= integ_d_ext - sgn_p16;
							PR_FFD: ccq_q <= integ_q_ext + sgn_p16;
							PR_PD: vd_q <= sgn_p16 + ccd_q;
							PR_PQ: begin
								vq_q <= vq_new;
								sd_q <= mag64(vd_q);
								sq_q <= mag64(vq_new);
								knz_q <= 1'b0;
							end
							PR_SD2: sqd_q <= acc_q;
							PR_SQ2: begin
								x_q <= sqd_q + acc_q;
								r_q <= '0;
								bit_q <= 64'd1 << 62;
							end
							PR_ND, PR_NQ: begin
								num_q <= acc_q;
								rem_q <= '0;
							end
							default: ;
						endcase
					end
				endcase
			end
			DP_NORM: begin
				sd_q <= sd_q >> 1;
				sq_q <= sq_q >> 1;
				knz_q <= 1'b1;
			end
			DP_SQRT: begin
				if (x_q >= rb) begin
					x_q <= x_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			DP_DIV: begin
				rem_q <= div_bit ? 32'(rem_sh - {1'b0, r_q[31:0]}) : rem_sh[31:0];
				num_q <= {num_q[WIDE-2:0], div_bit};
			end
			DP_DIV_END: begin
				if (cmd.prod == PR_ND) begin
					vd_q <= apply_sign(num_q, vd_q[WIDE-1]);
				end else begin
					vq_q <= apply_sign(num_q, vq_q[WIDE-1]);
				end
			end
			DP_OUT: begin
				out_q.voltage_d <= vd_q[31:0];
				out_q.voltage_q <= vq_q[31:0];
			end
			default: ;
		endcase
	end

	// status to the controller
	assign status.norm_done = (sd_q[WIDE-1:31] == '0) && (sq_q[WIDE-1:31] == '0);
	assign status.limit = knz_q || (r_q > {33'd0, vmax_q});
	assign status.m_zero = (r_q == '0);
	assign out_data = out_q;

endmodule

>>> rtl/dq_current_pi_controller_core.sv
`timescale 1ns / 1ps

// dq-axis PI current controller with decoupling feed-forward, vector voltage
// limiting and back-calculation anti-windup. One input beat is taken when the
// block is idle; the result beat sits in an output register, so the next input
// beat may be taken while it waits. All products go through one shared 32x32
// multiplier, each formed from two partial products that are summed and then
// written back (ten to twelve products per item), the vector magnitude through
// a one-bit-per-cycle square root followed by a decision on scaling and, only
// when the vector is scaled, a one-bit-per-cycle divider per axis followed by
// a step that applies the sign. A prescale of one cycle per bit above 31 is
// added for very large vectors. A new beat is taken only once the last one is
// through, including any wait for the output register to be freed.
// Configuration writes are taken at any time but must only be made while idle.
module dq_current_pi_controller_core #(
	parameter int DATA_WIDTH = dqpi_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dqpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dqpi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  dqpi_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output dqpi_pkg::out_item_t             out_data
);
	import dqpi_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	// sequencer
	dqpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	dqpi_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

	// an accepted beat makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken but block not busy");

	// result only written into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_OUT) |-> (!out_valid || !out_stall))
		else $error("output register overwritten");

	// divider never runs with a zero magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_DIV) |-> !status.m_zero)
		else $error("divide by zero magnitude");

endmodule
